// File: sv/nidh_pkg.sv
// shared types and constants of the nrzi interval dpll hdlc receiver
`timescale 1ns / 1ps
`default_nettype none
package nidh_pkg;

  localparam int TIME_W     = 16;
  localparam int IVL_W      = TIME_W + 4;
  localparam int PROD_W     = 2 * TIME_W;
  localparam int NXT_W      = TIME_W + 2;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int BITCNT_W   = 4;
  localparam int DIV_CNT_W  = $clog2(TIME_W);
  localparam int RES_DEPTH  = 3;
  localparam int RES_PTR_W  = 2;

  // floor(x / 5) as (x * ERR_RECIP) >> ERR_SHIFT, exact for x below 2**18
  localparam logic [TIME_W-1:0] ERR_RECIP = TIME_W'(52429);
  localparam int                ERR_SHIFT = 18;

  localparam logic [BYTE_W-1:0]   FLAG_BYTE  = 8'h7E;
  localparam logic [BYTE_W-1:0]   ABORT_BYTE = 8'h7F;
  localparam logic [BYTE_W-1:0]   DATA_MSB   = 8'h80;
  localparam logic [5:0]          STUFF_PAT  = 6'h3E;
  localparam logic [BITCNT_W-1:0] BYTE_BITS  = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAGS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE  = 3'd4;

  localparam logic [TIME_W-1:0] RST_NOMINAL = 16'd833;
  localparam logic [TIME_W-1:0] RST_MIN     = 16'd800;
  localparam logic [TIME_W-1:0] RST_MAX     = 16'd866;
  localparam logic [BYTE_W-1:0] RST_FLAGS   = 8'd2;
  localparam logic [BYTE_W-1:0] RST_ESCAPE  = 8'd27;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_CHECK,
    ST_BITS,
    ST_DIV,
    ST_UPDATE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic load;
    logic clamp;
    logic bit_step;
    logic div_step;
    logic bt_update;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic glitch;
    logic more_ones;
    logic div_last;
    logic res_any;
    logic res_last;
  } status_t;

endpackage
`default_nettype wire

// File: sv/nidh_ctrl.sv
// controller state machine of the nrzi interval dpll hdlc receiver
`timescale 1ns / 1ps
`default_nettype none
module nidh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output nidh_pkg::cmd_t    cmd,
  input  nidh_pkg::status_t sts
);

  nidh_pkg::state_t state_r;
  nidh_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nidh_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nidh_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = nidh_pkg::ST_ERR;
      end
      nidh_pkg::ST_ERR: begin
        state_nxt = nidh_pkg::ST_CHECK;
      end
      nidh_pkg::ST_CHECK: begin
        state_nxt = sts.glitch ? nidh_pkg::ST_IDLE : nidh_pkg::ST_BITS;
      end
      nidh_pkg::ST_BITS: begin
        if (!sts.more_ones) state_nxt = nidh_pkg::ST_DIV;
      end
      nidh_pkg::ST_DIV: begin
        if (sts.div_last) state_nxt = nidh_pkg::ST_UPDATE;
      end
      nidh_pkg::ST_UPDATE: begin
        state_nxt = sts.res_any ? nidh_pkg::ST_DRAIN : nidh_pkg::ST_IDLE;
      end
      nidh_pkg::ST_DRAIN: begin
        if (!out_stall && sts.res_last) state_nxt = nidh_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = nidh_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall      = (state_r != nidh_pkg::ST_IDLE);
    out_valid     = (state_r == nidh_pkg::ST_DRAIN);
    cmd.load      = (state_r == nidh_pkg::ST_IDLE) && in_valid;
    cmd.clamp     = (state_r == nidh_pkg::ST_CHECK) && !sts.glitch;
    cmd.bit_step  = (state_r == nidh_pkg::ST_BITS);
    cmd.div_step  = (state_r == nidh_pkg::ST_DIV);
    cmd.bt_update = (state_r == nidh_pkg::ST_UPDATE);
    cmd.pop       = (state_r == nidh_pkg::ST_DRAIN) && !out_stall;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result offered while input side open");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == nidh_pkg::ST_ERR))
    else $error("accepted item did not start processing");

  a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nidh_pkg::ST_DIV && !sts.div_last) |=> (state_r == nidh_pkg::ST_DIV))
    else $error("divider left early");

  a_drain_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nidh_pkg::ST_DRAIN) |-> sts.res_any)
    else $error("drain with empty result buffer");

endmodule
`default_nettype wire

// File: sv/nidh_dpath.sv
// datapath: bit timing, hdlc deframer, residue divider and result buffer
`timescale 1ns / 1ps
`default_nettype none
module nidh_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [nidh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nidh_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [nidh_pkg::TIME_W-1:0]         in_interval_ticks,
  input  nidh_pkg::cmd_t                      cmd,
  output nidh_pkg::status_t                   sts,
  output logic [nidh_pkg::BYTE_W-1:0]         out_byte,
  output logic                                out_carrier_detect,
  output logic                                out_last_of_item
);

  // configuration and tracker
  logic [nidh_pkg::TIME_W-1:0] bt_r;
  logic [nidh_pkg::TIME_W-1:0] min_r;
  logic [nidh_pkg::TIME_W-1:0] max_r;
  logic [nidh_pkg::BYTE_W-1:0] cfc_r;
  logic [nidh_pkg::BYTE_W-1:0] esc_r;
  logic [nidh_pkg::TIME_W-1:0] err_r;

  // interval walk
  logic [nidh_pkg::IVL_W-1:0]    ivl_r;
  logic [nidh_pkg::BITCNT_W-1:0] nbits_r;

  // deframer state
  logic [nidh_pkg::BYTE_W-1:0]   hist_r;
  logic                          in_frame_r;
  logic                          carrier_r;
  logic [nidh_pkg::BYTE_W-1:0]   flags_r;
  logic [nidh_pkg::BYTE_W-1:0]   partial_r;
  logic [nidh_pkg::BITCNT_W-1:0] bib_r;

  // divider
  logic [nidh_pkg::TIME_W-1:0]    q_r;
  logic [nidh_pkg::BITCNT_W-1:0]  rem_r;
  logic [nidh_pkg::BITCNT_W-1:0]  dvs_r;
  logic [nidh_pkg::DIV_CNT_W-1:0] dcnt_r;
  logic                           neg_r;

  // result buffer
  logic [nidh_pkg::BYTE_W-1:0]    res_byte_r [nidh_pkg::RES_DEPTH];
  logic                           res_cd_r   [nidh_pkg::RES_DEPTH];
  logic [nidh_pkg::RES_PTR_W-1:0] res_cnt_r;
  logic [nidh_pkg::RES_PTR_W-1:0] rd_ptr_r;

  // timing arithmetic
  logic [nidh_pkg::PROD_W-1:0] err_prod;
  logic [nidh_pkg::TIME_W-1:0] err_nxt;
  logic [nidh_pkg::TIME_W:0]   thr;
  logic [nidh_pkg::TIME_W-1:0] low_lim;
  logic [nidh_pkg::IVL_W-1:0]  thr_ext;
  logic [nidh_pkg::IVL_W-1:0]  long_lim;
  logic [nidh_pkg::IVL_W-1:0]  bt_ext;
  logic [nidh_pkg::IVL_W-1:0]  bt_x10;
  logic                        more_ones;
  logic [nidh_pkg::IVL_W-1:0]  pos_diff;
  logic [nidh_pkg::TIME_W-1:0] mag;
  logic                        mag_neg;

  assign err_prod = nidh_pkg::PROD_W'(bt_r) * nidh_pkg::PROD_W'(nidh_pkg::ERR_RECIP);
  assign err_nxt  = nidh_pkg::TIME_W'(err_prod >> nidh_pkg::ERR_SHIFT);
  assign thr      = {1'b0, bt_r} + {1'b0, err_r};
  assign low_lim  = bt_r - err_r;
  assign thr_ext  = nidh_pkg::IVL_W'(thr);
  assign long_lim = (thr_ext << 3) - thr_ext;
  assign bt_ext   = nidh_pkg::IVL_W'(bt_r);
  assign bt_x10   = (bt_ext << 3) + (bt_ext << 1);
  assign more_ones = (ivl_r > thr_ext);
  assign pos_diff = ivl_r - bt_ext;
  assign mag_neg  = (ivl_r < bt_ext);
  assign mag      = mag_neg ? (bt_r - ivl_r[nidh_pkg::TIME_W-1:0])
                            : pos_diff[nidh_pkg::TIME_W-1:0];

  // divider step
  logic [nidh_pkg::BITCNT_W:0]   div_t;
  logic [nidh_pkg::BITCNT_W:0]   div_sub;
  logic                          div_ge;

  assign div_t   = {rem_r, q_r[nidh_pkg::TIME_W-1]};
  assign div_sub = div_t - {1'b0, dvs_r};
  assign div_ge  = (div_t >= {1'b0, dvs_r});

  // tracker update
  logic signed [nidh_pkg::NXT_W-1:0] bt_s;
  logic signed [nidh_pkg::NXT_W-1:0] adj_s;
  logic signed [nidh_pkg::NXT_W-1:0] next_s;
  logic signed [nidh_pkg::NXT_W-1:0] max_s;
  logic signed [nidh_pkg::NXT_W-1:0] min_s;
  logic [nidh_pkg::TIME_W-1:0]       bt_new;
  logic                              bt_apply;

  assign bt_s   = $signed({2'b00, bt_r});
  assign adj_s  = $signed(nidh_pkg::NXT_W'(q_r[nidh_pkg::TIME_W-1:4]));
  assign next_s = neg_r ? (bt_s - adj_s) : (bt_s + adj_s);
  assign max_s  = $signed({2'b00, max_r});
  assign min_s  = $signed({2'b00, min_r});
  assign bt_apply = (q_r != '0) && !(neg_r && (q_r > err_r));

  always_comb begin
    if (next_s > max_s) begin
      bt_new = max_r;
    end else if (next_s < min_s) begin
      bt_new = min_r;
    end else begin
      bt_new = next_s[nidh_pkg::TIME_W-1:0];
    end
  end

  // deframer
  logic [nidh_pkg::BYTE_W-1:0]   hist_nxt;
  logic                          in_frame_nxt;
  logic                          carrier_nxt;
  logic [nidh_pkg::BYTE_W-1:0]   flags_nxt;
  logic [nidh_pkg::BYTE_W-1:0]   partial_nxt;
  logic [nidh_pkg::BITCNT_W-1:0] bib_nxt;
  logic [nidh_pkg::BYTE_W-1:0]   pb;
  logic [nidh_pkg::BITCNT_W-1:0] bib_inc;
  logic                          e0v;
  logic                          e1v;
  logic [nidh_pkg::BYTE_W-1:0]   e0b;
  logic [nidh_pkg::BYTE_W-1:0]   e1b;
  logic                          e0c;

  always_comb begin
    hist_nxt     = {hist_r[nidh_pkg::BYTE_W-2:0], more_ones};
    in_frame_nxt = in_frame_r;
    carrier_nxt  = carrier_r;
    flags_nxt    = flags_r;
    partial_nxt  = partial_r;
    bib_nxt      = bib_r;
    pb           = partial_r | (hist_nxt[0] ? nidh_pkg::DATA_MSB : '0);
    bib_inc      = bib_r + 1'b1;
    e0v          = 1'b0;
    e1v          = 1'b0;
    e0b          = pb;
    e1b          = pb;
    e0c          = carrier_r;
    if (hist_nxt == nidh_pkg::FLAG_BYTE) begin
      in_frame_nxt = 1'b1;
      if (flags_r < cfc_r) begin
        carrier_nxt = 1'b0;
        flags_nxt   = flags_r + 1'b1;
      end else begin
        carrier_nxt = 1'b1;
      end
      e0v         = 1'b1;
      e0b         = nidh_pkg::FLAG_BYTE;
      e0c         = carrier_nxt;
      partial_nxt = '0;
      bib_nxt     = '0;
    end else if (hist_nxt[6:0] == nidh_pkg::ABORT_BYTE[6:0]) begin
      in_frame_nxt = 1'b0;
      carrier_nxt  = 1'b0;
      flags_nxt    = '0;
    end else if (!in_frame_r) begin
      carrier_nxt = 1'b0;
      flags_nxt   = '0;
    end else if (hist_nxt[5:0] == nidh_pkg::STUFF_PAT) begin
      partial_nxt = partial_r;
    end else if (bib_inc >= nidh_pkg::BYTE_BITS) begin
      if (pb == nidh_pkg::FLAG_BYTE || pb == nidh_pkg::ABORT_BYTE || pb == esc_r) begin
        e0v = 1'b1;
        e0b = esc_r;
        e1v = 1'b1;
      end else begin
        e0v = 1'b1;
      end
      partial_nxt = '0;
      bib_nxt     = '0;
    end else begin
      partial_nxt = pb >> 1;
      bib_nxt     = bib_inc;
    end
  end

  // result buffer fill
  logic [nidh_pkg::RES_PTR_W:0] wr1;
  logic [nidh_pkg::RES_PTR_W:0] cnt_sum;
  logic [nidh_pkg::RES_PTR_W-1:0] res_cnt_nxt;

  assign wr1     = {1'b0, res_cnt_r} + 1'b1;
  assign cnt_sum = {1'b0, res_cnt_r} + {2'b00, e0v} + {2'b00, e1v};
  assign res_cnt_nxt = (cnt_sum > nidh_pkg::RES_DEPTH)
                       ? nidh_pkg::RES_PTR_W'(nidh_pkg::RES_DEPTH)
                       : cnt_sum[nidh_pkg::RES_PTR_W-1:0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < nidh_pkg::RES_DEPTH; i++) begin
      if (cmd.bit_step) begin
        if (e0v && res_cnt_r == nidh_pkg::RES_PTR_W'(i)) begin
          res_byte_r[i] <= e0b;
          res_cd_r[i]   <= e0c;
        end else if (e1v && wr1 == (nidh_pkg::RES_PTR_W + 1)'(i)) begin
          res_byte_r[i] <= e1b;
          res_cd_r[i]   <= carrier_r;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bt_r       <= nidh_pkg::RST_NOMINAL;
      min_r      <= nidh_pkg::RST_MIN;
      max_r      <= nidh_pkg::RST_MAX;
      cfc_r      <= nidh_pkg::RST_FLAGS;
      esc_r      <= nidh_pkg::RST_ESCAPE;
      hist_r     <= '0;
      in_frame_r <= 1'b0;
      carrier_r  <= 1'b0;
      flags_r    <= '0;
      partial_r  <= '0;
      bib_r      <= '0;
      res_cnt_r  <= '0;
      rd_ptr_r   <= '0;
      dcnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          nidh_pkg::CFG_NOMINAL: bt_r  <= cfg_data;
          nidh_pkg::CFG_MIN:     min_r <= cfg_data;
          nidh_pkg::CFG_MAX:     max_r <= cfg_data;
          nidh_pkg::CFG_FLAGS:   cfc_r <= cfg_data[nidh_pkg::BYTE_W-1:0];
          nidh_pkg::CFG_ESCAPE:  esc_r <= cfg_data[nidh_pkg::BYTE_W-1:0];
          default: begin
          end
        endcase
      end else if (cmd.bt_update && bt_apply) begin
        bt_r <= bt_new;
      end
      if (cmd.load) begin
        res_cnt_r <= '0;
        rd_ptr_r  <= '0;
      end
      if (cmd.bit_step) begin
        hist_r     <= hist_nxt;
        in_frame_r <= in_frame_nxt;
        carrier_r  <= carrier_nxt;
        flags_r    <= flags_nxt;
        partial_r  <= partial_nxt;
        bib_r      <= bib_nxt;
        res_cnt_r  <= res_cnt_nxt;
        if (!more_ones) dcnt_r <= '0;
      end
      if (cmd.div_step) dcnt_r <= dcnt_r + 1'b1;
      if (cmd.pop) rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    err_r <= err_nxt;
    if (cmd.load) begin
      ivl_r   <= nidh_pkg::IVL_W'(in_interval_ticks);
      nbits_r <= '0;
    end else if (cmd.clamp) begin
      if (ivl_r > long_lim) ivl_r <= bt_x10;
    end else if (cmd.bit_step) begin
      if (more_ones) begin
        ivl_r   <= ivl_r - bt_ext;
        nbits_r <= nbits_r + 1'b1;
      end else begin
        q_r   <= mag;
        rem_r <= '0;
        dvs_r <= nbits_r + 1'b1;
        neg_r <= mag_neg;
      end
    end
    if (cmd.div_step) begin
      q_r   <= {q_r[nidh_pkg::TIME_W-2:0], div_ge};
      rem_r <= div_ge ? div_sub[nidh_pkg::BITCNT_W-1:0] : div_t[nidh_pkg::BITCNT_W-1:0];
    end
  end

  assign sts.glitch    = (ivl_r < nidh_pkg::IVL_W'(low_lim));
  assign sts.more_ones = more_ones;
  assign sts.div_last  = (dcnt_r == nidh_pkg::DIV_CNT_W'(nidh_pkg::TIME_W - 1));
  assign sts.res_any   = (res_cnt_r != '0);
  assign sts.res_last  = (rd_ptr_r == res_cnt_r - 1'b1);

  assign out_byte           = res_byte_r[rd_ptr_r];
  assign out_carrier_detect = res_cd_r[rd_ptr_r];
  assign out_last_of_item   = sts.res_last;

endmodule
`default_nettype wire

// File: sv/nrzi_interval_dpll_hdlc_receiver_core.sv
// top level of the nrzi interval dpll hdlc receiver
// Each transfer on the in_ channel is the tick count between two line transitions.
// Short glitches are dropped in the check state with no output. Otherwise the interval
// is walked one NRZI bit per cycle (1 to 10 bits) through the HDLC deframer, the
// timing residue is divided by the bit count in a bit-serial divider, the bit-time
// tracker is trimmed unless the quotient is zero or, for a short interval, above err_r,
// and then 0 to 3 bytes are handed out, the last one marked with out_last_of_item.
// in_stall stays high from acceptance until the item ends as a glitch, with no bytes,
// or with its last byte transferred. Configuration writes are always ready and take
// effect at once; writing the nominal bit time also reloads the tracker.
`timescale 1ns / 1ps
`default_nettype none
module nrzi_interval_dpll_hdlc_receiver_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [nidh_pkg::TIME_W-1:0]         in_interval_ticks,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [nidh_pkg::BYTE_W-1:0]         out_byte,
  output logic                                out_carrier_detect,
  output logic                                out_last_of_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nidh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nidh_pkg::CFG_DATA_W-1:0]     cfg_data
);

  nidh_pkg::cmd_t    cmd;
  nidh_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  nidh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  nidh_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_interval_ticks  (in_interval_ticks),
    .cmd                (cmd),
    .sts                (sts),
    .out_byte           (out_byte),
    .out_carrier_detect (out_carrier_detect),
    .out_last_of_item   (out_last_of_item)
  );

endmodule
`default_nettype wire
